/* sv/redo_log_transaction_tracker_unit_assert.svh */
// Assertion macros for the redo log transaction tracker checks
`ifndef REDO_LOG_TRANSACTION_TRACKER_UNIT_ASSERT_SVH
`define REDO_LOG_TRANSACTION_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define RLTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rltt check failed");

// next-cycle implication, off during reset
`define RLTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rltt check failed");

// next-cycle implication that also holds across reset
`define RLTT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rltt check failed");

`endif

/* sv/rltt_pkg.sv */
// Package: types, codes and constants of the redo log transaction tracker
`timescale 1ns / 1ps

package rltt_pkg;

    localparam int LOG_CAPACITY_DEF = 30;
    localparam int QUEUE_DEPTH      = 2;
    localparam int COUNT_W          = 5;
    localparam int OPEN_W           = 6;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 32;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_AREA  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OP    = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MUST_WAIT  = 3'd1;
    localparam logic [2:0] ST_TOO_BIG    = 3'd2;
    localparam logic [2:0] ST_OUTSIDE_TX = 3'd3;
    localparam logic [2:0] ST_END_NO_OP  = 3'd4;

    localparam logic [1:0] ACT_ACK    = 2'd0;
    localparam logic [1:0] ACT_COPY   = 2'd1;
    localparam logic [1:0] ACT_HEADER = 2'd2;

    localparam logic [31:0] LOG_START_RST = 32'd2;
    localparam logic [6:0]  LOG_AREA_RST  = 7'd30;
    localparam logic [4:0]  MAX_OP_RST    = 5'd10;

    typedef enum logic [1:0] {
        KIND_BEGIN,
        KIND_END,
        KIND_WRITE,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] block_number;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  action;
        logic [31:0] source_block;
        logic [31:0] dest_block;
        logic [4:0]  header_count;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] block_number;
    } queue_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_C1_RD,
        S_C1_OUT,
        S_HDR1,
        S_C2_RD,
        S_C2_OUT,
        S_HDR2
    } state_t;

endpackage

/* sv/rltt_front.sv */
// Front end: accepts input beats, classifies the command, queues them
`timescale 1ns / 1ps

module rltt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rltt_pkg::in_beat_t    s_data,
    output logic                  q_valid,
    output rltt_pkg::queue_entry_t q_entry,
    input  logic                  q_pop
);

    localparam int PTR_W = (rltt_pkg::QUEUE_DEPTH > 1) ? $clog2(rltt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rltt_pkg::QUEUE_DEPTH + 1);

    rltt_pkg::queue_entry_t slot_reg [rltt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rltt_pkg::queue_entry_t entry_in;
    logic push, pop;

    always_comb begin
        entry_in.block_number = s_data.block_number;
        case (s_data.command)
            rltt_pkg::CMD_BEGIN: entry_in.kind = rltt_pkg::KIND_BEGIN;
            rltt_pkg::CMD_END:   entry_in.kind = rltt_pkg::KIND_END;
            rltt_pkg::CMD_WRITE: entry_in.kind = rltt_pkg::KIND_WRITE;
            default:             entry_in.kind = rltt_pkg::KIND_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != CNT_W'(rltt_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rltt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rltt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

/* sv/rltt_back.sv */
// Back end: transaction state, block table, commit sequencer, result register
`timescale 1ns / 1ps

module rltt_back #(
    parameter int LOG_CAPACITY = rltt_pkg::LOG_CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rltt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rltt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_valid,
    input  rltt_pkg::queue_entry_t              q_entry,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rltt_pkg::out_beat_t                 m_data
);

    localparam int IDX_W = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;
    localparam int CW    = rltt_pkg::COUNT_W;
    localparam int OW    = rltt_pkg::OPEN_W;

    rltt_pkg::state_t state_reg, state_next;

    logic [31:0] log_start_reg;
    logic [6:0]  log_area_reg;
    logic [4:0]  max_op_reg;

    logic [OW-1:0]    open_reg, open_next;
    logic [CW-1:0]    logged_reg, logged_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       status_reg, status_next;
    logic [31:0]      blk_reg, blk_next;

    logic [31:0] table_mem [LOG_CAPACITY];
    logic [31:0] rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;

    logic                m_valid_reg, m_valid_next;
    rltt_pkg::out_beat_t out_reg, out_next;
    logic                out_load;
    logic                out_free;

    logic [OW:0]     open_inc;
    logic [11:0]     need;
    logic            begin_ok;
    logic            full;
    logic            cnt_last;
    logic [31:0]     slot_blk;

    assign out_free = !m_valid_reg || m_ready;
    assign open_inc = {1'b0, open_reg} + 1'b1;
    assign need     = 12'(logged_reg) + 12'(open_inc) * 12'(max_op_reg);
    assign begin_ok = (open_reg != {OW{1'b1}}) && (need <= 12'(LOG_CAPACITY));
    assign full     = (logged_reg >= CW'(LOG_CAPACITY))
                   || ({3'b000, logged_reg} + 8'd1 >= {1'b0, log_area_reg});
    assign cnt_last = (CW'(cnt_reg) + 1'b1 == logged_reg);
    assign slot_blk = log_start_reg + 32'(cnt_reg) + 32'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rltt_pkg::S_IDLE: begin
                if (q_valid) begin
                    case (q_entry.kind)
                        rltt_pkg::KIND_END: begin
                            if (open_reg == OW'(1) && logged_reg != '0) begin
                                state_next = rltt_pkg::S_C1_RD;
                            end else begin
                                state_next = rltt_pkg::S_ACK;
                            end
                        end
                        rltt_pkg::KIND_WRITE: begin
                            if (full || open_reg == '0 || logged_reg == '0) begin
                                state_next = rltt_pkg::S_ACK;
                            end else begin
                                state_next = rltt_pkg::S_SRCH_RD;
                            end
                        end
                        default: state_next = rltt_pkg::S_ACK;
                    endcase
                end
            end
            rltt_pkg::S_ACK:      if (out_free) state_next = rltt_pkg::S_IDLE;
            rltt_pkg::S_SRCH_RD:  state_next = rltt_pkg::S_SRCH_CMP;
            rltt_pkg::S_SRCH_CMP: begin
                if (rdata_reg == blk_reg || cnt_last) begin
                    state_next = rltt_pkg::S_ACK;
                end else begin
                    state_next = rltt_pkg::S_SRCH_RD;
                end
            end
            rltt_pkg::S_C1_RD:    state_next = rltt_pkg::S_C1_OUT;
            rltt_pkg::S_C1_OUT: begin
                if (out_free) begin
                    state_next = cnt_last ? rltt_pkg::S_HDR1 : rltt_pkg::S_C1_RD;
                end
            end
            rltt_pkg::S_HDR1:     if (out_free) state_next = rltt_pkg::S_C2_RD;
            rltt_pkg::S_C2_RD:    state_next = rltt_pkg::S_C2_OUT;
            rltt_pkg::S_C2_OUT: begin
                if (out_free) begin
                    state_next = cnt_last ? rltt_pkg::S_HDR2 : rltt_pkg::S_C2_RD;
                end
            end
            rltt_pkg::S_HDR2:     if (out_free) state_next = rltt_pkg::S_IDLE;
            default:              state_next = rltt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        q_pop       = 1'b0;
        open_next   = open_reg;
        logged_next = logged_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        blk_next    = blk_reg;
        mem_we      = 1'b0;
        mem_wa      = logged_reg[IDX_W-1:0];
        out_load    = 1'b0;
        out_next    = '0;
        out_next.status = status_reg;
        out_next.last   = 1'b1;
        unique case (state_reg)
            rltt_pkg::S_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    blk_next    = q_entry.block_number;
                    cnt_next    = '0;
                    status_next = rltt_pkg::ST_OK;
                    case (q_entry.kind)
                        rltt_pkg::KIND_BEGIN: begin
                            if (begin_ok) begin
                                open_next = open_reg + 1'b1;
                            end else begin
                                status_next = rltt_pkg::ST_MUST_WAIT;
                            end
                        end
                        rltt_pkg::KIND_END: begin
                            if (open_reg == '0) begin
                                status_next = rltt_pkg::ST_END_NO_OP;
                            end else begin
                                open_next = open_reg - 1'b1;
                            end
                        end
                        rltt_pkg::KIND_WRITE: begin
                            if (full) begin
                                status_next = rltt_pkg::ST_TOO_BIG;
                            end else if (open_reg == '0) begin
                                status_next = rltt_pkg::ST_OUTSIDE_TX;
                            end else if (logged_reg == '0) begin
                                mem_we      = 1'b1;
                                logged_next = CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rltt_pkg::S_ACK: begin
                out_load = out_free;
            end
            rltt_pkg::S_SRCH_RD: ;
            rltt_pkg::S_SRCH_CMP: begin
                if (rdata_reg != blk_reg) begin
                    if (cnt_last) begin
                        mem_we      = 1'b1;
                        logged_next = logged_reg + 1'b1;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            rltt_pkg::S_C1_RD: ;
            rltt_pkg::S_C1_OUT: begin
                out_next.action       = rltt_pkg::ACT_COPY;
                out_next.source_block = rdata_reg;
                out_next.dest_block   = slot_blk;
                out_next.last         = 1'b0;
                if (out_free) begin
                    out_load = 1'b1;
                    cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                end
            end
            rltt_pkg::S_HDR1: begin
                out_next.action       = rltt_pkg::ACT_HEADER;
                out_next.dest_block   = log_start_reg;
                out_next.header_count = logged_reg;
                out_next.last         = 1'b0;
                out_load              = out_free;
            end
            rltt_pkg::S_C2_RD: ;
            rltt_pkg::S_C2_OUT: begin
                out_next.action       = rltt_pkg::ACT_COPY;
                out_next.source_block = slot_blk;
                out_next.dest_block   = rdata_reg;
                out_next.last         = 1'b0;
                if (out_free) begin
                    out_load = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rltt_pkg::S_HDR2: begin
                out_next.action     = rltt_pkg::ACT_HEADER;
                out_next.dest_block = log_start_reg;
                if (out_free) begin
                    out_load    = 1'b1;
                    logged_next = '0;
                end
            end
            default: ;
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rltt_pkg::S_IDLE;
            open_reg      <= '0;
            logged_reg    <= '0;
            m_valid_reg   <= 1'b0;
            log_start_reg <= rltt_pkg::LOG_START_RST;
            log_area_reg  <= rltt_pkg::LOG_AREA_RST;
            max_op_reg    <= rltt_pkg::MAX_OP_RST;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            logged_reg  <= logged_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    rltt_pkg::CFG_LOG_START: log_start_reg <= cfg_data;
                    rltt_pkg::CFG_LOG_AREA:  log_area_reg  <= cfg_data[6:0];
                    rltt_pkg::CFG_MAX_OP:    max_op_reg    <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        blk_reg    <= blk_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_wa] <= blk_next;
        end
        rdata_reg <= table_mem[cnt_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* sv/redo_log_transaction_tracker_unit.sv */
// Top level of the redo log transaction tracker
//
//   channel  direction  ports                          beat
//   s_       in         s_valid s_ready s_data         command, block number
//   m_       out        m_valid m_ready m_data         status, action, blocks, count, last
//   cfg_     in         cfg_wr_en cfg_index cfg_data   register write, no wait
//
// Begin, end without commit, and error beats: one result beat each.
// Log write: searches the table entry by entry (single-port table, registered read).
// Commit of n blocks: 2n+2 result beats.
// Synchronous active-low reset clears counts and queue; table contents are not cleared.
// A stalled m_ready holds the sequencer; the 2-beat input queue takes beats meanwhile until it is full.
`timescale 1ns / 1ps

module redo_log_transaction_tracker_unit #(
    parameter int LOG_CAPACITY = rltt_pkg::LOG_CAPACITY_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rltt_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rltt_pkg::out_beat_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [rltt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rltt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                   q_valid;
    logic                   q_pop;
    rltt_pkg::queue_entry_t q_entry;

    rltt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    rltt_back #(
        .LOG_CAPACITY (LOG_CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* sv/rltt_checker.sv */
// Port-level checks for the redo log transaction tracker, with bind
`timescale 1ns / 1ps
`include "redo_log_transaction_tracker_unit_assert.svh"

module rltt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rltt_pkg::out_beat_t m_data
);

    `RLTT_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid)
    `RLTT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `RLTT_ASSERT_SAME(a_copy_not_last, aclk, aresetn, m_valid && m_data.action == rltt_pkg::ACT_COPY, !m_data.last && m_data.status == rltt_pkg::ST_OK)
    `RLTT_ASSERT_SAME(a_ack_shape, aclk, aresetn, m_valid && m_data.action == rltt_pkg::ACT_ACK, m_data.last && m_data.source_block == '0 && m_data.dest_block == '0)
    `RLTT_ASSERT_NEXT(a_copy_follows, aclk, aresetn, m_valid && m_ready && m_data.action == rltt_pkg::ACT_COPY, !m_valid || m_data.action == rltt_pkg::ACT_COPY || m_data.action == rltt_pkg::ACT_HEADER)

endmodule

bind redo_log_transaction_tracker_unit rltt_checker u_rltt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/redo_log_transaction_tracker_unit_tb.sv */
// Testbench for the redo log transaction tracker: directed and random commands, scoreboarded
`timescale 1ns / 1ps

module redo_log_transaction_tracker_unit_tb;
    import rltt_pkg::*;

    localparam int          LOG_CAP = LOG_CAPACITY_DEF;
    localparam logic [1:0]  CMD_NOP = 2'd3;
    localparam int          PHASES  = 6;

    class redo_commit_scoreboard;
        logic [31:0] log_start = LOG_START_RST;
        logic [6:0]  log_area  = LOG_AREA_RST;
        logic [4:0]  max_op    = MAX_OP_RST;
        int          open_ops;
        int          logged;
        logic [31:0] home_blocks [LOG_CAP];
        out_beat_t   expected_q [$];
        int          errors;
        int          inputs_seen;
        int          beats_seen;
        int          commits;
        int          largest_commit;
        int          status_hits [5];

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_LOG_START: log_start = data;
                CFG_LOG_AREA:  log_area  = data[6:0];
                CFG_MAX_OP:    max_op    = data[4:0];
                default: ;
            endcase
        endfunction

        function void push(logic [2:0] st, logic [1:0] act, logic [31:0] src,
                           logic [31:0] dst, logic [4:0] cnt, logic lst);
            out_beat_t e;
            e.status       = st;
            e.action       = act;
            e.source_block = src;
            e.dest_block   = dst;
            e.header_count = cnt;
            e.last         = lst;
            expected_q.push_back(e);
        endfunction

        function logic [31:0] slot_of(int t);
            return log_start + 32'd1 + 32'(t);
        endfunction

        function void note_input(in_beat_t b);
            int need;
            int i;
            inputs_seen++;
            case (b.command)
                CMD_BEGIN: begin
                    need = logged + (open_ops + 1) * int'(max_op);
                    if (open_ops >= 63 || need > LOG_CAP) begin
                        push(ST_MUST_WAIT, ACT_ACK, '0, '0, '0, 1'b1);
                    end else begin
                        open_ops++;
                        push(ST_OK, ACT_ACK, '0, '0, '0, 1'b1);
                    end
                end
                CMD_END: begin
                    if (open_ops == 0) begin
                        push(ST_END_NO_OP, ACT_ACK, '0, '0, '0, 1'b1);
                    end else begin
                        open_ops--;
                        if (open_ops != 0 || logged == 0) begin
                            push(ST_OK, ACT_ACK, '0, '0, '0, 1'b1);
                        end else begin
                            for (i = 0; i < logged; i++)
                                push(ST_OK, ACT_COPY, home_blocks[i], slot_of(i), '0, 1'b0);
                            push(ST_OK, ACT_HEADER, '0, log_start, 5'(logged), 1'b0);
                            for (i = 0; i < logged; i++)
                                push(ST_OK, ACT_COPY, slot_of(i), home_blocks[i], '0, 1'b0);
                            push(ST_OK, ACT_HEADER, '0, log_start, '0, 1'b1);
                            commits++;
                            if (logged > largest_commit)
                                largest_commit = logged;
                            logged = 0;
                        end
                    end
                end
                CMD_WRITE: begin
                    if (logged >= LOG_CAP || logged + 1 >= int'(log_area)) begin
                        push(ST_TOO_BIG, ACT_ACK, '0, '0, '0, 1'b1);
                    end else if (open_ops < 1) begin
                        push(ST_OUTSIDE_TX, ACT_ACK, '0, '0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < logged; i++)
                            if (home_blocks[i] == b.block_number)
                                break;
                        if (i == logged) begin
                            home_blocks[i] = b.block_number;
                            logged++;
                        end
                        push(ST_OK, ACT_ACK, '0, '0, '0, 1'b1);
                    end
                end
                default: push(ST_OK, ACT_ACK, '0, '0, '0, 1'b1);
            endcase
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            beats_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("status", 32'(want.status), 32'(got.status));
            compare("action", 32'(want.action), 32'(got.action));
            compare("source_block", want.source_block, got.source_block);
            compare("dest_block", want.dest_block, got.dest_block);
            compare("header_count", 32'(want.header_count), 32'(got.header_count));
            compare("last", 32'(want.last), 32'(got.last));
            if (got.last === 1'b1 && got.status < 3'd5)
                status_hits[got.status]++;
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_beat_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_beat_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   no_idle   = 1'b0;

    redo_commit_scoreboard sb = new;

    redo_log_transaction_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 38);
    end

    // both handshakes sampled on the pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    task automatic send_command(logic [1:0] cmd, logic [31:0] blk);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 38)
                gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_data.command       <= cmd;
        s_data.block_number  <= blk;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle(int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic program_regs(logic [31:0] start, logic [6:0] area, logic [4:0] max_op);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOG_START;
        cfg_data  <= start;
        @(posedge aclk);
        cfg_index <= CFG_LOG_AREA;
        cfg_data  <= 32'(area);
        @(posedge aclk);
        cfg_index <= CFG_MAX_OP;
        cfg_data  <= 32'(max_op);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(CFG_LOG_START, start);
        sb.set_reg(CFG_LOG_AREA, 32'(area));
        sb.set_reg(CFG_MAX_OP, 32'(max_op));
    endtask

    // 63 opens with no reservation, then one refused, a few writes and the unwind
    task automatic open_op_flood();
        int k;
        for (k = 0; k < 64; k++)
            send_command(CMD_BEGIN, $urandom);
        for (k = 0; k < 3; k++)
            send_command(CMD_WRITE, $urandom);
        for (k = 0; k < 64; k++)
            send_command(CMD_END, $urandom);
    endtask

    task automatic run_transactions(int budget);
        int          sent;
        int          ops;
        int          writes;
        int          k;
        logic [31:0] pool [8];
        logic [31:0] blk;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 15) begin
                send_command(2'($urandom_range(3)), $urandom);
                sent++;
                continue;
            end
            ops    = $urandom_range(1, 3);
            writes = ($urandom_range(5) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 10);
            for (k = 0; k < 8; k++)
                pool[k] = $urandom;
            for (k = 0; k < ops; k++)
                send_command(CMD_BEGIN, $urandom);
            for (k = 0; k < writes; k++) begin
                blk = (writes <= 10 && $urandom_range(1) == 1) ? pool[$urandom_range(7)]
                                                               : $urandom;
                send_command(CMD_WRITE, blk);
            end
            for (k = 0; k < ops; k++)
                send_command(CMD_END, $urandom);
            sent += 2 * ops + writes;
            if ($urandom_range(9) == 0) begin
                send_command(CMD_END, $urandom);
                sent++;
            end
            if ($urandom_range(7) == 0)
                settle(0);
        end
    endtask

    initial begin
        logic [31:0] starts [PHASES];
        logic [6:0]  areas  [PHASES];
        logic [4:0]  maxops [PHASES];
        int          p;

        starts = '{32'h0000_0000, 32'hFFFF_FFF0, $urandom, $urandom, $urandom, $urandom};
        areas  = '{7'd64, 7'd40, 7'd2, 7'($urandom_range(2, 64)), 7'd64,
                   7'($urandom_range(2, 64))};
        maxops = '{5'd1, 5'd5, 5'd1, 5'($urandom_range(1, 30)), 5'd30,
                   5'($urandom_range(1, 30))};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register reset values: stray commands, admission limit, absorb, commit
        send_command(CMD_NOP, 32'hFFFF_FFFF);
        send_command(CMD_END, 32'h0);
        send_command(CMD_WRITE, 32'h0);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_BEGIN, 32'hFFFF_FFFF);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_WRITE, 32'hFFFF_FFFF);
        send_command(CMD_WRITE, 32'h0000_0000);
        send_command(CMD_WRITE, 32'hFFFF_FFFF);
        send_command(CMD_END, 32'h0);
        send_command(CMD_END, 32'h0);
        send_command(CMD_END, 32'h0);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_END, 32'h0);
        settle(70);

        // one-block log area, header at the top of the address space
        program_regs(32'hFFFF_FFFF, 7'd2, 5'd30);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_WRITE, 32'h8000_0001);
        send_command(CMD_WRITE, 32'h7FFF_FFFE);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_END, 32'h0);
        settle(70);

        // log area too small for anything: full check wins over no open op
        program_regs(32'd5, 7'd1, 5'd30);
        send_command(CMD_WRITE, 32'h1234_5678);
        send_command(CMD_BEGIN, 32'h0);
        send_command(CMD_WRITE, 32'h1234_5678);
        send_command(CMD_END, 32'h0);
        settle(70);

        program_regs($urandom, 7'd64, 5'd0);
        no_idle <= 1'b1;
        open_op_flood();
        no_idle <= 1'b0;
        settle(70);

        for (p = 0; p < PHASES; p++) begin
            program_regs(starts[p], areas[p], maxops[p]);
            no_idle <= (p == 0);
            run_transactions(6);
            settle(70);
        end
        no_idle <= 1'b0;
        settle(70);

        $display("Run covered %0d commands and %0d result beats, %0d commits, largest %0d blocks.",
                 sb.inputs_seen, sb.beats_seen, sb.commits, sb.largest_commit);
        $display("Final beats by status: ok %0d, must-wait %0d, too-big %0d, %s %0d, %s %0d.",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 "outside", sb.status_hits[3], "stray end", sb.status_hits[4]);
        if (sb.errors == 0) begin
            $display("redo_log_transaction_tracker_unit verification clean");
        end else begin
            $display("redo_log_transaction_tracker_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("redo_log_transaction_tracker_unit verification failed");
        $finish;
    end

endmodule
